### design/lzt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzt_pkg: shared types for the LZ77 token encoder
// Holds the byte type that the compare cells and the top level both use.
// ----------------------------------------------------------------------------
package lzt_pkg;

  // One uncompressed byte.
  typedef logic [7:0] byte_t;

endpackage

### design/lzt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzt_cell: one compare cell of the candidate chain
// Holds one candidate byte, hands it to its neighbor when the chain shifts,
// and compares it with the lookahead byte at the same offset.
// ----------------------------------------------------------------------------
module lzt_cell
  import lzt_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t byte_i,
  input  byte_t ref_i,
  output byte_t byte_o,
  output logic  eq_o
);

  byte_t byte_q;

  // The held byte moves one cell toward the head on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign eq_o   = (byte_q == ref_i);

endmodule

### design/lz77_token_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_token_encoder: greedy LZ77 encoder with a chain of compare cells
// Turns a byte stream into (distance, length, literal) tokens.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle until the lookahead is full or a byte with
// tlast arrives; then the block stops taking input and searches. The search
// streams every candidate byte of the history (one memory read per cycle)
// followed by the lookahead through a chain of LOOKAHEAD_SIZE-1 compare cells.
// The length+1 consumed bytes then move into the history, one memory write
// per cycle, the last write waiting until the output register can take the
// token. In steady state one token follows every length+1 input bytes.
// After tlast the lookahead is flushed completely and the next byte starts
// a new, independent stream. WINDOW_SIZE must be a power of two.
module lz77_token_encoder
  import lzt_pkg::*;
#(
  parameter int WINDOW_SIZE    = 1024,
  parameter int LOOKAHEAD_SIZE = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic s_axis_tlast,         // final_byte
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // match_distance, match_length, next_literal (lowest bits first)
  output logic [((($clog2(WINDOW_SIZE) + $clog2(LOOKAHEAD_SIZE) + 8) + 7) / 8) * 8 - 1:0]
               m_axis_tdata,
  output logic m_axis_tlast          // last_token
);

  localparam int AW   = $clog2(WINDOW_SIZE);
  localparam int FW   = AW + 1;
  localparam int LW   = $clog2(LOOKAHEAD_SIZE);
  localparam int CNTW = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int M    = LOOKAHEAD_SIZE - 1;
  localparam int SW   = $clog2(WINDOW_SIZE + LOOKAHEAD_SIZE + 1);
  localparam int DW   = (((AW + LW + 8) + 7) / 8) * 8;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_ADV    = 2'd3;

  logic [1:0] state_q, state_d;

  // History memory and stream state.
  byte_t           ring_q [WINDOW_SIZE];
  byte_t           ram_rd_q;
  byte_t           la_q   [LOOKAHEAD_SIZE];
  logic [CNTW-1:0] count_q;
  logic [FW-1:0]   fill_q;
  logic [AW-1:0]   wp_q;
  logic            fin_q;

  // Search control.
  logic [LW-1:0]   max_len_q;
  logic [AW-1:0]   max_dist_q;
  logic [SW-1:0]   total_q;
  logic [SW-1:0]   iss_q;
  logic [SW-1:0]   ent_q;
  logic            vld1_q;
  logic            src_ring_q;
  byte_t           la_rd_q;
  logic            shifted_q;
  logic [LW-1:0]   best_len_q;
  logic [AW-1:0]   best_dist_q;
  logic [LW:0]     adv_q;

  // Output register.
  logic            out_vld_q;
  logic [AW-1:0]   out_dist_q;
  logic [LW-1:0]   out_len_q;
  byte_t           out_lit_q;
  logic            out_last_q;

  logic in_acc, adv_step, adv_last, out_free;
  logic [SW-1:0] p_pos, la_off;
  logic [AW-1:0] rd_addr;
  logic eval;
  logic [LW-1:0] j_len;
  logic run;
  byte_t chain_in;
  byte_t cell_byte [M+1];
  logic [M-1:0] cell_eq;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv_last      = (adv_q == (LW+1)'(1));
  assign adv_step      = (state_q == ST_ADV) && (!adv_last || out_free);

  // Chain of compare cells; new bytes enter at the tail.
  assign chain_in  = src_ring_q ? ram_rd_q : la_rd_q;
  assign cell_byte[M] = chain_in;
  for (genvar g = 0; g < M; g++) begin : g_cell
    lzt_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(vld1_q),
      .byte_i (cell_byte[g+1]),
      .ref_i  (la_q[g]),
      .byte_o (cell_byte[g]),
      .eq_o   (cell_eq[g])
    );
  end

  // Candidate at the chain head and its match length.
  assign p_pos = ent_q - SW'(M);
  assign eval  = shifted_q && (ent_q >= SW'(M)) && (p_pos < SW'(max_dist_q));
  always_comb begin
    j_len = '0;
    run   = 1'b1;
    for (int k = 0; k < M; k++) begin
      if (run && (LW'(k) < max_len_q) && cell_eq[k]) begin
        j_len = j_len + LW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  // Read address of the next streamed byte.
  assign rd_addr = wp_q - max_dist_q + iss_q[AW-1:0];
  assign la_off  = iss_q - SW'(max_dist_q);

  // History memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (adv_step) begin
      ring_q[wp_q] <= la_q[0];
    end
    ram_rd_q <= ring_q[rd_addr];
  end

  // Lookahead: appended on input, shifted out during advance.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      la_q[count_q[LW-1:0]] <= s_axis_tdata;
    end else if (adv_step) begin
      for (int k = 0; k < LOOKAHEAD_SIZE - 1; k++) begin
        la_q[k] <= la_q[k+1];
      end
    end
  end

  // Streaming source select and lookahead byte pick.
  always_ff @(posedge clk_i) begin
    src_ring_q <= (iss_q < SW'(max_dist_q));
    la_rd_q    <= la_q[la_off[LW-1:0]];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tlast || (count_q == CNTW'(LOOKAHEAD_SIZE - 1)))) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_SEARCH;
      ST_SEARCH: begin
        if ((ent_q == total_q) && !shifted_q && !vld1_q && (iss_q == total_q)) begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        if (adv_step && adv_last) begin
          state_d = (fin_q && (count_q != CNTW'(1))) ? ST_SETUP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fill_q      <= '0;
      wp_q        <= '0;
      fin_q       <= 1'b0;
      max_len_q   <= '0;
      max_dist_q  <= '0;
      total_q     <= '0;
      iss_q       <= '0;
      ent_q       <= '0;
      vld1_q      <= 1'b0;
      shifted_q   <= 1'b0;
      best_len_q  <= '0;
      best_dist_q <= '0;
      adv_q       <= '0;
      out_vld_q   <= 1'b0;
      out_dist_q  <= '0;
      out_len_q   <= '0;
      out_lit_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      vld1_q    <= 1'b0;
      shifted_q <= vld1_q;
      if (vld1_q) begin
        ent_q <= ent_q + SW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            count_q <= count_q + CNTW'(1);
            fin_q   <= s_axis_tlast;
          end
        end
        ST_SETUP: begin
          max_len_q   <= LW'(count_q - CNTW'(1));
          max_dist_q  <= (fill_q < FW'(WINDOW_SIZE - 1)) ? fill_q[AW-1:0]
                                                         : AW'(WINDOW_SIZE - 1);
          total_q     <= ((fill_q < FW'(WINDOW_SIZE - 1)) ? SW'(fill_q)
                                                          : SW'(WINDOW_SIZE - 1))
                         + SW'(M - 1);
          iss_q       <= '0;
          ent_q       <= '0;
          best_len_q  <= '0;
          best_dist_q <= '0;
        end
        ST_SEARCH: begin
          if (iss_q != total_q) begin
            iss_q  <= iss_q + SW'(1);
            vld1_q <= 1'b1;
          end
          // Later candidates are nearer, so equal lengths replace.
          if (eval && (j_len != '0) && (j_len >= best_len_q)) begin
            best_len_q  <= j_len;
            best_dist_q <= AW'(SW'(max_dist_q) - p_pos);
          end
          adv_q <= (LW+1)'(best_len_q) + (LW+1)'(1);
          if (eval && (j_len != '0) && (j_len >= best_len_q)) begin
            adv_q <= (LW+1)'(j_len) + (LW+1)'(1);
          end
        end
        ST_ADV: begin
          if (adv_step) begin
            adv_q   <= adv_q - (LW+1)'(1);
            count_q <= count_q - CNTW'(1);
            wp_q    <= wp_q + AW'(1);
            if (fill_q < FW'(WINDOW_SIZE)) begin
              fill_q <= fill_q + FW'(1);
            end
            if (adv_last) begin
              out_vld_q  <= 1'b1;
              out_dist_q <= best_dist_q;
              out_len_q  <= best_len_q;
              out_lit_q  <= la_q[0];
              out_last_q <= fin_q && (count_q == CNTW'(1));
              if (fin_q && (count_q == CNTW'(1))) begin
                fill_q  <= '0;
                wp_q    <= '0;
                count_q <= '0;
                fin_q   <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result word.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DW'({out_lit_q, out_len_q, out_dist_q});
  assign m_axis_tlast  = out_last_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LZ77 token encoder
// Streams of bytes go in through a queue-fed driver; a monitor compares each
// output token field by field against tokens predicted by a software encoder.
// ----------------------------------------------------------------------------
module testbench
  import lzt_pkg::*;
();

  localparam int WIN  = 1024;
  localparam int LOOK = 8;

  typedef struct {
    byte_t data;
    bit    fin;
    bit    drain;  // Wait until every token has arrived before sending.
  } in_word_t;

  typedef struct {
    logic [9:0] distance;
    logic [2:0] len;
    byte_t      lit;
    logic       fin;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  lz77_token_encoder u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: history, lookahead and their counters.
  byte_t hist_mem [WIN];
  byte_t look_mem [LOOK];
  int    hist_fill, wr_ptr, look_cnt;

  in_word_t byte_queue[$];
  token_t   token_queue[$];
  int       mismatches, tokens_seen, bytes_sent, streams;
  bit       taken, calm, long_hold;

  function automatic byte_t cand_at(int d, int k);
    if (k < d) return hist_mem[(wr_ptr + WIN - d + k) % WIN];
    return look_mem[(k - d) % LOOK];
  endfunction

  // Find the longest nearest match, queue its token and shift the lookahead.
  task automatic encode_token(bit fin);
    int max_len, max_dist, best_len, best_dist, j, adv;
    token_t t;
    max_len   = (look_cnt - 1 > LOOK - 1) ? LOOK - 1 : look_cnt - 1;
    max_dist  = (hist_fill < WIN - 1) ? hist_fill : WIN - 1;
    best_len  = 0;
    best_dist = 0;
    for (int d = 1; d <= max_dist; d++) begin
      j = 0;
      while (j < max_len && cand_at(d, j) == look_mem[j]) j++;
      if (j > best_len) begin
        best_len  = j;
        best_dist = d;
      end
    end
    t.distance = best_dist[9:0];
    t.len      = best_len[2:0];
    t.lit      = look_mem[best_len];
    adv = best_len + 1;
    for (int k = 0; k < adv; k++) begin
      hist_mem[wr_ptr] = look_mem[k];
      wr_ptr = (wr_ptr + 1) % WIN;
      if (hist_fill < WIN) hist_fill++;
    end
    for (int k = 0; k + adv < look_cnt; k++) look_mem[k] = look_mem[k + adv];
    look_cnt -= adv;
    t.fin = fin && (look_cnt == 0);
    token_queue = {token_queue, t};
  endtask

  task automatic predict_byte(in_word_t w);
    int n;
    n = 0;
    if (look_cnt < LOOK) begin
      look_mem[look_cnt] = w.data;
      look_cnt++;
    end
    if (w.fin) begin
      while (look_cnt > 0 && n < LOOK) begin
        encode_token(1'b1);
        n++;
      end
      hist_fill = 0;
      wr_ptr    = 0;
      look_cnt  = 0;
      streams++;
    end else if (look_cnt >= LOOK) begin
      encode_token(1'b0);
    end
  endtask

  task automatic add_stream(int len, bit narrow);
    in_word_t w;
    byte_t base;
    base = byte_t'($urandom);
    for (int i = 0; i < len; i++) begin
      w.data  = narrow ? byte_t'(base + $urandom_range(0, 3)) : byte_t'($urandom);
      w.fin   = (i == len - 1);
      w.drain = 1'b0;
      byte_queue = {byte_queue, w};
    end
  endtask

  task automatic add_byte(byte_t b, bit fin, bit drain);
    in_word_t w;
    w.data  = b;
    w.fin   = fin;
    w.drain = drain;
    byte_queue = {byte_queue, w};
  endtask

  // Accept side of the input: predict every byte the block takes.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_byte(byte_queue[0]);
      bytes_sent++;
      taken = 1'b1;
    end
  end

  // Driver: present the queue head at the falling edge, with random gaps.
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic v;
    v = s_axis_tvalid;
    if (taken) begin
      void'(byte_queue.pop_front());
      taken = 1'b0;
      v = 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
    end
    if (rst_ni && !v) begin
      if (gap_left > 0) gap_left--;
      else if (byte_queue.size() > 0 &&
               !(byte_queue[0].drain && token_queue.size() > 0)) begin
        v = 1'b1;
        s_axis_tdata <= byte_queue[0].data;
        s_axis_tlast <= byte_queue[0].fin;
      end
    end
    s_axis_tvalid <= v;
  end

  // Receiver ready: random stall bursts plus one long hold-off.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || long_hold) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each token word with the oldest prediction.
  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token word %h", m_axis_tdata);
      end else begin
        e = token_queue.pop_front();
        if (m_axis_tdata[9:0] !== e.distance || m_axis_tdata[12:10] !== e.len ||
            m_axis_tdata[20:13] !== e.lit || m_axis_tdata[23:21] !== 3'b000 ||
            m_axis_tlast !== e.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: exp dist %0d len %0d lit %h last %b, got %0d %0d %h %b",
                     e.distance, e.len, e.lit, e.fin, m_axis_tdata[9:0],
                     m_axis_tdata[12:10], m_axis_tdata[20:13], m_axis_tlast);
        end
      end
    end
  end

  // Long receiver hold-off, so the block backs up and stalls its input.
  initial begin
    long_hold = 1'b0;
    wait (bytes_sent >= 60);
    @(negedge clk_i);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk_i);
    @(negedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int total;
    hist_fill = 0; wr_ptr = 0; look_cnt = 0;
    mismatches = 0; tokens_seen = 0; bytes_sent = 0; streams = 0;
    taken = 1'b0; calm = 1'b0;

    // Directed: extreme bytes alone, a long run, a tie and a full flush.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++) add_byte(8'h41, i == 11, 1'b0);
    for (int i = 0; i < 8; i++) add_byte(i[0] ? 8'h79 : 8'h78, i == 7, 1'b0);

    // Random: mostly short streams over a narrow alphabet to get matches.
    total = 22;
    while (total < 180) begin
      int n;
      n = $urandom_range(1, 30);
      if (n > 180 - total) n = 180 - total;
      if (total == 22) begin
        add_byte(byte_t'($urandom), 1'b0, 1'b1);
        add_stream(n, 1'b1);
        n++;
      end else begin
        add_stream(n, $urandom_range(0, 4) != 0);
      end
      total += n;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (byte_queue.size() < 30);
    calm = 1'b1;
    wait (byte_queue.size() == 0 && token_queue.size() == 0);
    repeat (1100) @(posedge clk_i);

    $display("Sent %0d bytes in %0d streams, checked %0d tokens.",
             bytes_sent, streams, tokens_seen);
    $display("Mismatches: %0d, tokens still expected: %0d.",
             mismatches, token_queue.size());
    if (mismatches == 0 && token_queue.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
design/lzt_pkg.sv
design/lzt_cell.sv
design/lz77_token_encoder.sv
verif/testbench.sv
